>>> rtl/core/fxalu_pkg.sv
// fxalu_pkg: shared types, constants and opcodes for the fixed-point ALU.
// No dependencies.
package fxalu_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DW        = 32;
  // Divider: magnitude numerator is 32+FRAC_BITS bits wide, one quotient bit per cell.
  localparam int NUM_W     = DW + FRAC_BITS;
  localparam int NCELLS    = NUM_W;
  localparam int QW        = NUM_W + 1;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT  = 4'd4, OP_LT  = 4'd5, OP_GE  = 4'd6, OP_LE  = 4'd7,
    OP_EQ  = 4'd8, OP_NE  = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_SAT = 2'd1, ST_DIVZ = 2'd2
  } status_t;

  // Item travelling down the chain: preliminary result plus divider state.
  typedef struct packed {
    logic              vld;
    logic              is_div;
    logic              neg;
    logic [DW-1:0]     res;
    logic              cmp;
    status_t           status;
    logic [NUM_W-1:0]  num;   // numerator bits, consumed msb first
    logic [DW:0]       rem;   // partial remainder
    logic [DW-1:0]     den;   // divisor magnitude
    logic [NUM_W-1:0]  quo;   // quotient bits so far
  } slot_t;

  localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

endpackage

>>> rtl/core/fxalu_if.sv
// fxalu_if: valid/ready channel interfaces for operations and results.
// No dependencies.
interface fxalu_in_if;
  logic                    valid;
  logic                    ready;
  logic [3:0]              opcode;
  logic signed [31:0]      operand_a;
  logic signed [31:0]      operand_b;
  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fxalu_out_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      result;
  logic                    compare_true;
  logic [1:0]              status;
  modport source (output valid, result, compare_true, status, input ready);
  modport sink   (input valid, result, compare_true, status, output ready);
endinterface

>>> rtl/core/fxalu_front.sv
// fxalu_front: entry stage; finishes all ops but multiply and divide, and sets up divide.
// The product is registered here and then rounded/saturated combinationally at the module output.
// Depends on fxalu_pkg.
module fxalu_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [3:0]                in_op,
  input  logic signed [31:0]        in_a,
  input  logic signed [31:0]        in_b,
  output fxalu_pkg::slot_t          slot_o
);
  import fxalu_pkg::*;

  slot_t              s_r, s_nxt;
  logic               is_mul_r;
  logic signed [63:0] prod_r;
  logic signed [33:0] wide;
  logic [DW-1:0]      mag_a, mag_b;
  logic signed [DW+FRAC_BITS:0] shl;
  opcode_t            op;

  function automatic logic [DW+1:0] sat34(input logic signed [33:0] v, output logic sat);
    logic [DW+1:0] r;
    sat = 1'b0;
    r = v;
    if (v > 34'(signed'(S_MAX))) begin
      sat = 1'b1; r = 34'(signed'(S_MAX));
    end else if (v < 34'(signed'(S_MIN))) begin
      sat = 1'b1; r = 34'(signed'(S_MIN));
    end
    return r;
  endfunction

  always_comb begin
    logic sat;
    logic [DW+1:0] t;
    op     = opcode_t'(in_op);
    mag_a  = in_a[DW-1] ? DW'(-in_a) : in_a;
    mag_b  = in_b[DW-1] ? DW'(-in_b) : in_b;
    shl    = (DW+FRAC_BITS+1)'(signed'(in_a)) <<< FRAC_BITS;
    wide   = '0;
    sat    = 1'b0;
    t      = '0;
    s_nxt  = '0;
    s_nxt.vld    = in_vld;
    s_nxt.status = ST_OK;
    s_nxt.den    = mag_b;
    s_nxt.num    = {mag_a, {FRAC_BITS{1'b0}}};
    s_nxt.neg    = in_a[DW-1] ^ in_b[DW-1];
    unique case (op)
      OP_ADD: begin
        wide = 34'(in_a) + 34'(in_b);
        t = sat34(wide, sat); s_nxt.res = t[DW-1:0];
        s_nxt.status = sat ? ST_SAT : ST_OK;
      end
      OP_SUB: begin
        wide = 34'(in_a) - 34'(in_b);
        t = sat34(wide, sat); s_nxt.res = t[DW-1:0];
        s_nxt.status = sat ? ST_SAT : ST_OK;
      end
      OP_INC: begin
        wide = 34'(in_a) + 34'sd1;
        t = sat34(wide, sat); s_nxt.res = t[DW-1:0];
        s_nxt.status = sat ? ST_SAT : ST_OK;
      end
      OP_DEC: begin
        wide = 34'(in_a) - 34'sd1;
        t = sat34(wide, sat); s_nxt.res = t[DW-1:0];
        s_nxt.status = sat ? ST_SAT : ST_OK;
      end
      OP_GT: s_nxt.cmp = in_a >  in_b;
      OP_LT: s_nxt.cmp = in_a <  in_b;
      OP_GE: s_nxt.cmp = in_a >= in_b;
      OP_LE: s_nxt.cmp = in_a <= in_b;
      OP_EQ: s_nxt.cmp = in_a == in_b;
      OP_NE: s_nxt.cmp = in_a != in_b;
      OP_MIN: s_nxt.res = (in_a <  in_b) ? in_a : in_b;
      OP_MAX: s_nxt.res = (in_a >  in_b) ? in_a : in_b;
      OP_TOINT: s_nxt.res = in_a >>> FRAC_BITS;
      OP_FROMINT: begin
        if (shl > (DW+FRAC_BITS+1)'(signed'(S_MAX))) begin
          s_nxt.res = S_MAX; s_nxt.status = ST_SAT;
        end else if (shl < (DW+FRAC_BITS+1)'(signed'(S_MIN))) begin
          s_nxt.res = S_MIN; s_nxt.status = ST_SAT;
        end else begin
          s_nxt.res = shl[DW-1:0];
        end
      end
      OP_MUL: ;
      OP_DIV: begin
        if (in_b == '0) begin
          s_nxt.status = ST_DIVZ;
          s_nxt.res = in_a[DW-1] ? S_MIN : ((in_a == '0) ? '0 : S_MAX);
        end else begin
          s_nxt.is_div = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else if (en) begin
      s_r      <= s_nxt;
      is_mul_r <= (opcode_t'(in_op) == OP_MUL);
      prod_r   <= in_a * in_b;
    end
  end

  // Second stage of multiply: round half away from zero, then saturate.
  always_comb begin
    logic [63:0] m, q;
    logic        pn;
    slot_o = s_r;
    pn = prod_r[63];
    m  = pn ? 64'(-prod_r) : 64'(prod_r);
    q  = (m + ((FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS > 0 ? FRAC_BITS-1 : 0)) : 64'd0))
         >> FRAC_BITS;
    if (is_mul_r) begin
      if (!pn && q > 64'(S_MAX)) begin
        slot_o.res = S_MAX; slot_o.status = ST_SAT;
      end else if (pn && q > 64'h8000_0000) begin
        slot_o.res = S_MIN; slot_o.status = ST_SAT;
      end else begin
        slot_o.res = pn ? DW'(-q) : q[DW-1:0];
      end
    end
  end

endmodule

>>> rtl/core/fxalu_cell.sv
// fxalu_cell: one restoring-division step per cell; other items pass through.
// Depends on fxalu_pkg.
module fxalu_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  fxalu_pkg::slot_t  slot_i,
  output fxalu_pkg::slot_t  slot_o
);
  import fxalu_pkg::*;

  slot_t         s_r, s_nxt;
  logic [DW:0]   trial;
  logic [DW+1:0] diff;

  always_comb begin
    s_nxt = slot_i;
    trial = {slot_i.rem[DW-1:0], slot_i.num[NUM_W-1]};
    diff  = {1'b0, trial} - {2'b0, slot_i.den};
    s_nxt.num = slot_i.num << 1;
    if (slot_i.is_div) begin
      if (!diff[DW+1]) begin
        s_nxt.rem = diff[DW:0];
        s_nxt.quo = {slot_i.quo[NUM_W-2:0], 1'b1};
      end else begin
        s_nxt.rem = trial;
        s_nxt.quo = {slot_i.quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else if (en) begin
      s_r <= s_nxt;
    end
  end

  assign slot_o = s_r;

endmodule

>>> rtl/core/fxalu_back.sv
// fxalu_back: divide rounding and saturation, output register.
// Depends on fxalu_pkg and fxalu_if.
module fxalu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fxalu_pkg::slot_t    slot_i,
  output logic                en,
  fxalu_out_if.source         out_ch
);
  import fxalu_pkg::*;

  logic          vld_r;
  logic [DW-1:0] res_r, res_nxt;
  logic          cmp_r;
  status_t       st_r, st_nxt;
  logic [QW-1:0] q;

  // Chain advances when the output register is empty or being drained.
  assign en = !vld_r || out_ch.ready;

  always_comb begin
    res_nxt = slot_i.res;
    st_nxt  = slot_i.status;
    // round: r >= den - r  <=>  2r >= den
    q = {1'b0, slot_i.quo} + QW'({slot_i.rem, 1'b0} >= {1'b0, slot_i.den});
    if (slot_i.is_div) begin
      if (!slot_i.neg && q > QW'(S_MAX)) begin
        res_nxt = S_MAX; st_nxt = ST_SAT;
      end else if (slot_i.neg && q > QW'(64'h8000_0000)) begin
        res_nxt = S_MIN; st_nxt = ST_SAT;
      end else begin
        res_nxt = slot_i.neg ? DW'(-q) : q[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= slot_i.vld;
      res_r <= res_nxt;
      cmp_r <= slot_i.cmp;
      st_r  <= st_nxt;
    end
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.result       = res_r;
  assign out_ch.compare_true = cmp_r;
  assign out_ch.status       = st_r;

endmodule

>>> rtl/core/fixed_point_alu.sv
// fixed_point_alu: pipelined signed fixed-point ALU, top level.
// Depends on fxalu_pkg, fxalu_if, fxalu_front, fxalu_cell, fxalu_back.
//
// Takes one item per cycle and returns one result per item, in order. Every
// item walks the same pipeline: an entry register (add/sub/compare/min/max/
// inc/dec/toint/fromint finished here, multiply product registered and then
// rounded combinationally ahead of the first cell), a chain of 40
// (32+FRAC_BITS) divider cells, each producing one quotient bit, and an
// output register that rounds the quotient half away from zero and
// saturates. That is 42 registers, and every opcode passes through all of
// them; throughput is one item per cycle while results are taken. The whole
// chain stalls together when the result is not taken; the input is ready
// whenever the output register is empty or being drained.
module fixed_point_alu (
  input  logic        clk,
  input  logic        rst_n,
  fxalu_in_if.sink    in_ch,
  fxalu_out_if.source out_ch
);
  import fxalu_pkg::*;

  logic  en;
  slot_t chain [NCELLS+1];

  assign in_ch.ready = en;

  fxalu_front u_front (
    .clk, .rst_n, .en,
    .in_vld (in_ch.valid),
    .in_op  (in_ch.opcode),
    .in_a   (in_ch.operand_a),
    .in_b   (in_ch.operand_b),
    .slot_o (chain[0])
  );

  // divider chain: cell k decides quotient bit NUM_W-1-k
  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    fxalu_cell u_cell (
      .clk, .rst_n, .en,
      .slot_i (chain[k]),
      .slot_o (chain[k+1])
    );
  end

  fxalu_back u_back (
    .clk, .rst_n,
    .slot_i (chain[NCELLS]),
    .en,
    .out_ch
  );

endmodule

>>> rtl/core/fxalu_checker.sv
// fxalu_checker: port-level assertions for fixed_point_alu, bound to it.
// Depends on fxalu_pkg.
module fxalu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        in_ready,
  input logic [31:0] out_result,
  input logic        out_compare_true,
  input logic [1:0]  out_status
);
  import fxalu_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed under stall");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status code");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_result == '0 && out_status == ST_OK)
    else $error("compare result not clean");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");

endmodule

bind fixed_point_alu fxalu_checker u_fxalu_checker (
  .clk, .rst_n,
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .in_ready         (in_ch.ready),
  .out_result       (out_ch.result),
  .out_compare_true (out_ch.compare_true),
  .out_status       (out_ch.status)
);

>>> tb/fxalu_sb.sv
// fxalu_sb: scoreboard for the fixed-point ALU testbench. Holds the predictor
// and the queue of expected results. Depends on fxalu_pkg.
import fxalu_pkg::*;

typedef struct {
  logic signed [31:0] result;
  logic               compare_true;
  status_t            status;
} alu_result_t;

class fxalu_sb;
  alu_result_t pending_q[$];
  int unsigned errors;
  int unsigned checked;

  static function logic signed [31:0] sat32(longint v, ref status_t st);
    if (v > 64'sd2147483647) begin
      st = ST_SAT;
      return S_MAX;
    end
    if (v < -64'sd2147483648) begin
      st = ST_SAT;
      return S_MIN;
    end
    return v[31:0];
  endfunction

  // Exact multiply, rounded to nearest with ties away from zero.
  static function longint mul_round(longint a, longint b);
    longint p;
    longint unsigned m;
    p = a * b;
    m = (p < 0) ? -p : p;
    if (FRAC_BITS > 0) m = m + (64'd1 << (FRAC_BITS - 1));
    m = m >> FRAC_BITS;
    return (p < 0) ? -longint'(m) : longint'(m);
  endfunction

  static function longint div_round(longint a, longint b);
    longint unsigned num, den, q, r;
    num = ((a < 0) ? -a : a) << FRAC_BITS;
    den = (b < 0) ? -b : b;
    q = num / den;
    r = num % den;
    if (r >= den - r) q++;
    return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
  endfunction

  static function alu_result_t predict(opcode_t op, logic signed [31:0] ra,
                                       logic signed [31:0] rb);
    alu_result_t e;
    longint a, b;
    a = ra;
    b = rb;
    e.result = '0;
    e.compare_true = 1'b0;
    e.status = ST_OK;
    case (op)
      OP_ADD:     e.result = sat32(a + b, e.status);
      OP_SUB:     e.result = sat32(a - b, e.status);
      OP_MUL:     e.result = sat32(mul_round(a, b), e.status);
      OP_DIV: begin
        if (b == 0) begin
          e.status = ST_DIVZ;
          e.result = (a > 0) ? S_MAX : ((a < 0) ? S_MIN : '0);
        end else begin
          e.result = sat32(div_round(a, b), e.status);
        end
      end
      OP_GT:      e.compare_true = a > b;
      OP_LT:      e.compare_true = a < b;
      OP_GE:      e.compare_true = a >= b;
      OP_LE:      e.compare_true = a <= b;
      OP_EQ:      e.compare_true = a == b;
      OP_NE:      e.compare_true = a != b;
      OP_MIN:     e.result = (a < b) ? ra : rb;
      OP_MAX:     e.result = (a > b) ? ra : rb;
      OP_INC:     e.result = sat32(a + 1, e.status);
      OP_DEC:     e.result = sat32(a - 1, e.status);
      OP_TOINT:   e.result = ra >>> FRAC_BITS;
      OP_FROMINT: e.result = sat32(a * (64'sd1 <<< FRAC_BITS), e.status);
      default:    e.result = '0;
    endcase
    return e;
  endfunction

  function void note_op(opcode_t op, logic signed [31:0] a, logic signed [31:0] b);
    pending_q.push_back(predict(op, a, b));
  endfunction

  function void check_result(logic signed [31:0] res, logic cmp, logic [1:0] st);
    alu_result_t e;
    checked++;
    if (pending_q.size() == 0) begin
      $error("unexpected result %0d", res);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (res !== e.result) begin
      $error("result: expected %0d, got %0d", e.result, res);
      errors++;
    end
    if (cmp !== e.compare_true) begin
      $error("compare_true: expected %0b, got %0b", e.compare_true, cmp);
      errors++;
    end
    if (st !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, st);
      errors++;
    end
  endfunction
endclass

>>> tb/fixed_point_alu_tb.sv
// fixed_point_alu_tb: self-checking testbench for the fixed-point ALU.
// Depends on fxalu_pkg, fxalu_if, fxalu_sb and the RTL.
module fixed_point_alu_tb;
  import fxalu_pkg::*;

  logic clk;
  logic rst_n;

  fxalu_in_if  in_ch();
  fxalu_out_if out_ch();

  fixed_point_alu u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  fxalu_sb sb;
  int unsigned sent;
  bit stall_mode;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit: ~2k items, generous gaps and stalls.
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Operand picker: edge values often, random words otherwise.
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      4: return $signed($urandom_range(0, 2047)) - 1024;     // small values
      5: return $signed($urandom_range(0, 65535) << FRAC_BITS); // whole numbers
      6: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $signed($urandom());
    endcase
  endfunction

  // Drive one item and hold it until accepted.
  task automatic send_op(opcode_t op, logic signed [31:0] a, logic signed [31:0] b);
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_op(op, a, b);
    sent++;
  endtask

  task automatic idle_gap(int unsigned n);
    if (n == 0) return;
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Receiver: sample at the edge, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.result, out_ch.compare_true, out_ch.status);
      if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
      // stall phase: mostly blocked; free phase: full speed
      out_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  initial begin
    opcode_t op;
    int unsigned burst;
    int unsigned wait_cyc;
    sb = new();
    sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: saturation both ways, rounding ties, divide by zero, toint.
    send_op(OP_ADD, S_MAX, 32'sd1);
    send_op(OP_SUB, S_MIN, 32'sd1);
    send_op(OP_MUL, S_MAX, S_MAX);
    send_op(OP_MUL, S_MIN, S_MIN);
    send_op(OP_MUL, 32'sd1, 32'sd128);        // exact half tie
    send_op(OP_MUL, -32'sd1, 32'sd128);       // negative tie
    send_op(OP_DIV, 32'sd100, 32'sd0);
    send_op(OP_DIV, -32'sd100, 32'sd0);
    send_op(OP_DIV, 32'sd0, 32'sd0);
    send_op(OP_DIV, S_MIN, 32'sd1);           // overflows
    send_op(OP_DIV, S_MIN, -32'sd1);
    send_op(OP_DIV, 32'sd1, 32'sd512);        // tie in division
    send_op(OP_GT, S_MAX, S_MIN);
    send_op(OP_LT, S_MIN, S_MAX);
    send_op(OP_GE, 32'sd5, 32'sd5);
    send_op(OP_LE, 32'sd5, 32'sd5);
    send_op(OP_EQ, -32'sd7, -32'sd7);
    send_op(OP_NE, 32'sd0, -32'sd1);
    send_op(OP_MIN, 32'sd3, 32'sd3);
    send_op(OP_MAX, S_MIN, S_MAX);
    send_op(OP_INC, S_MAX, 32'sd0);
    send_op(OP_DEC, S_MIN, -32'sd1);
    send_op(OP_TOINT, -32'sd1, 32'sd0);       // rounds toward minus infinity
    send_op(OP_FROMINT, 32'sd8388608, 32'sd0);
    send_op(OP_FROMINT, -32'sd8388609, 32'sd0);

    // Random bursts with random gaps; some bursts run back to back.
    while (sent < 2025) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        op = opcode_t'($urandom_range(0, 15));
        send_op(op, pick_operand(), pick_operand());
      end
      wait_cyc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      idle_gap(wait_cyc);
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("ran %0d items over all 16 opcodes, %0d results checked",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/fxalu_pkg.sv
rtl/core/fxalu_if.sv
rtl/core/fxalu_front.sv
rtl/core/fxalu_cell.sv
rtl/core/fxalu_back.sv
rtl/core/fixed_point_alu.sv
rtl/core/fxalu_checker.sv
tb/fxalu_sb.sv
tb/fixed_point_alu_tb.sv
